@@ hdl/ucdc_pkg.sv @@
// Package: types, constants and descriptor ROM for the CDC control endpoint.
`timescale 1ns / 1ps
`default_nettype none
package ucdc_pkg;

    localparam int MaxPacketDefault = 64;

    typedef enum logic [1:0] {
        FUNC_SETUP  = 2'd0,
        FUNC_OUT    = 2'd1,
        FUNC_IN_CPL = 2'd2,
        FUNC_BUSRST = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ACT_DATA  = 3'd0,
        ACT_ZLP   = 3'd1,
        ACT_ARM0  = 3'd2,
        ACT_ARM1  = 3'd3,
        ACT_ADDR  = 3'd4,
        ACT_NONE  = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        SRC_DEV  = 3'd0,
        SRC_CFG  = 3'd1,
        SRC_S0   = 3'd2,
        SRC_S1   = 3'd3,
        SRC_S2   = 3'd4,
        SRC_STAT = 3'd5,
        SRC_CFGB = 3'd6,
        SRC_LC   = 3'd7
    } t_src;

    localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
    localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
    localparam logic [7:0] REQ_GET_DESC    = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG  = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
    localparam logic [7:0] REQ_SET_LC      = 8'h20;
    localparam logic [7:0] REQ_GET_LC      = 8'h21;
    localparam logic [7:0] REQ_SET_CLS     = 8'h22;
    localparam logic [7:0] DT_DEVICE       = 8'h01;
    localparam logic [7:0] DT_CONFIG       = 8'h02;
    localparam logic [7:0] DT_STRING       = 8'h03;
    localparam logic [55:0] LC_RESET       = 56'h08_0000_0001_C200;

    typedef struct packed {
        logic [55:0] out_bytes;
        logic [6:0]  out_count;
        logic [15:0] request_length;
        logic [15:0] request_value;
        logic [7:0]  request_code;
        logic [7:0]  request_type;
        logic [1:0]  func;
    } t_req;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        packet_end;
        logic [6:0]  device_address;
        logic        configured;
        logic [1:0]  ctrl_lines;
        logic        last;
    } t_res;

    function automatic logic [7:0] rom_byte(input logic [2:0] src, input logic [6:0] i);
        logic [7:0] b;
        b = 8'h00;
        unique case (src)
            SRC_DEV: begin
                unique case (i)
                    7'd0: b = 8'h12; 7'd1: b = 8'h01; 7'd2: b = 8'h00; 7'd3: b = 8'h02;
                    7'd4: b = 8'hEF; 7'd5: b = 8'h02; 7'd6: b = 8'h01; 7'd7: b = 8'h40;
                    7'd8: b = 8'h83; 7'd9: b = 8'h04; 7'd10: b = 8'h40; 7'd11: b = 8'h57;
                    7'd12: b = 8'h00; 7'd13: b = 8'h02; 7'd14: b = 8'h01; 7'd15: b = 8'h02;
                    7'd16: b = 8'h03; 7'd17: b = 8'h01;
                    default: b = 8'h00;
                endcase
            end
            SRC_CFG: begin
                unique case (i)
                    7'd0: b = 8'h09; 7'd1: b = 8'h02; 7'd2: b = 8'h4B; 7'd3: b = 8'h00;
                    7'd4: b = 8'h02; 7'd5: b = 8'h01; 7'd6: b = 8'h00; 7'd7: b = 8'hC0;
                    7'd8: b = 8'h32;
                    7'd9: b = 8'h08; 7'd10: b = 8'h0B; 7'd11: b = 8'h00; 7'd12: b = 8'h02;
                    7'd13: b = 8'h02; 7'd14: b = 8'h02; 7'd15: b = 8'h00; 7'd16: b = 8'h00;
                    7'd17: b = 8'h09; 7'd18: b = 8'h04; 7'd19: b = 8'h00; 7'd20: b = 8'h00;
                    7'd21: b = 8'h01; 7'd22: b = 8'h02; 7'd23: b = 8'h02; 7'd24: b = 8'h00;
                    7'd25: b = 8'h00;
                    7'd26: b = 8'h05; 7'd27: b = 8'h24; 7'd28: b = 8'h00; 7'd29: b = 8'h10;
                    7'd30: b = 8'h01;
                    7'd31: b = 8'h04; 7'd32: b = 8'h24; 7'd33: b = 8'h02; 7'd34: b = 8'h02;
                    7'd35: b = 8'h05; 7'd36: b = 8'h24; 7'd37: b = 8'h06; 7'd38: b = 8'h00;
                    7'd39: b = 8'h01;
                    7'd40: b = 8'h05; 7'd41: b = 8'h24; 7'd42: b = 8'h01; 7'd43: b = 8'h00;
                    7'd44: b = 8'h01;
                    7'd45: b = 8'h07; 7'd46: b = 8'h05; 7'd47: b = 8'h82; 7'd48: b = 8'h03;
                    7'd49: b = 8'h0A; 7'd50: b = 8'h00; 7'd51: b = 8'h10;
                    7'd52: b = 8'h09; 7'd53: b = 8'h04; 7'd54: b = 8'h01; 7'd55: b = 8'h00;
                    7'd56: b = 8'h02; 7'd57: b = 8'h0A; 7'd58: b = 8'h00; 7'd59: b = 8'h00;
                    7'd60: b = 8'h00;
                    7'd61: b = 8'h07; 7'd62: b = 8'h05; 7'd63: b = 8'h01; 7'd64: b = 8'h02;
                    7'd65: b = 8'h40; 7'd66: b = 8'h00; 7'd67: b = 8'h00;
                    7'd68: b = 8'h07; 7'd69: b = 8'h05; 7'd70: b = 8'h81; 7'd71: b = 8'h02;
                    7'd72: b = 8'h40; 7'd73: b = 8'h00; 7'd74: b = 8'h00;
                    default: b = 8'h00;
                endcase
            end
            SRC_S0: begin
                unique case (i)
                    7'd0: b = 8'h04; 7'd1: b = 8'h03; 7'd2: b = 8'h09; 7'd3: b = 8'h04;
                    default: b = 8'h00;
                endcase
            end
            SRC_S1: begin
                unique case (i)
                    7'd0: b = 8'h12; 7'd1: b = 8'h03; 7'd2: b = 8'h6A; 7'd4: b = 8'h6F;
                    7'd6: b = 8'h63; 7'd8: b = 8'h2D; 7'd10: b = 8'h62; 7'd12: b = 8'h61;
                    7'd14: b = 8'h73; 7'd16: b = 8'h65;
                    default: b = 8'h00;
                endcase
            end
            SRC_S2: begin
                unique case (i)
                    7'd0: b = 8'h10; 7'd1: b = 8'h03; 7'd2: b = 8'h43; 7'd4: b = 8'h44;
                    7'd6: b = 8'h43; 7'd8: b = 8'h2D; 7'd10: b = 8'h41; 7'd12: b = 8'h43;
                    7'd14: b = 8'h4D;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

@@ hdl/ucdc_if.sv @@
// Valid/ready stream interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface ucdc_req_if;
    logic             valid;
    logic             ready;
    ucdc_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ucdc_res_if;
    logic             valid;
    logic             ready;
    ucdc_pkg::t_res   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/usb_cdc_control_endpoint_unit.sv @@
// Top level: USB CDC-ACM endpoint-0 control responder with a byte-serial packer.
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        t_req (func, setup fields, out data)
//  o_res     out  valid/ready        t_res (action, word, flags, last)
//
// A request is registered, decoded in S_DECODE, then results leave one at a time.
// Each data word is assembled by one shared ROM byte port, one byte per cycle:
// S_WORD starts the word, S_BYTE gathers its bytes and S_EMIT presents it.
// Requests with only queued actions go from S_DECODE through S_WORD to S_TAIL, which
// presents one result per queued action.
// Stalls on o_res hold the sequencer.
// Synchronous active-low reset restores line coding and clears the FSM, counters and flags.
`timescale 1ns / 1ps
`default_nettype none
module usb_cdc_control_endpoint_unit #(
    parameter int MAX_PACKET = ucdc_pkg::MaxPacketDefault
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ucdc_req_if.sink     i_req,
    ucdc_res_if.source   o_res
);
    localparam int Cw = $clog2(MAX_PACKET + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_BYTE, S_WORD, S_TAIL, S_EMIT
    } t_state;

    t_state      r_state;
    ucdc_pkg::t_req r_req;
    logic [6:0]  r_pend_addr;
    logic [7:0]  r_cfg_val;
    logic [55:0] r_lc;
    logic [1:0]  r_lines;
    logic        r_out_pend;
    logic [2:0]  r_src;
    logic [6:0]  r_rem, r_off;
    logic [Cw-1:0] r_chunk_left;
    logic [3:0]  r_bidx, r_bcnt;
    logic [63:0] r_word;
    // queued trailing actions, up to 2
    logic [2:0]  r_q [2];
    logic [6:0]  r_q_addr;
    logic [1:0]  r_qn;
    logic        r_valid;
    ucdc_pkg::t_res r_out;

    logic [7:0]  w_byte;
    logic [6:0]  w_clip;
    logic [2:0]  w_dsrc;
    logic        w_dok;
    logic        w_load;

    always_comb begin
        unique case (r_src)
            ucdc_pkg::SRC_CFGB: w_byte = (r_off == 7'd0 && r_cfg_val != 8'd0) ? 8'd1 : 8'd0;
            ucdc_pkg::SRC_LC:   w_byte = (r_off < 7'd7) ? r_lc[{r_off[2:0], 3'b000} +: 8]
                                                        : 8'd0;
            default:            w_byte = ucdc_pkg::rom_byte(r_src, r_off);
        endcase
    end

    // descriptor selection and clipping
    always_comb begin
        logic [6:0] n;
        n = 7'd0;
        w_dok = 1'b1;
        w_dsrc = ucdc_pkg::SRC_DEV;
        if (r_req.request_value[15:8] == ucdc_pkg::DT_DEVICE) begin
            n = 7'd18; w_dsrc = ucdc_pkg::SRC_DEV;
        end else if (r_req.request_value[15:8] == ucdc_pkg::DT_CONFIG) begin
            n = 7'd75; w_dsrc = ucdc_pkg::SRC_CFG;
        end else if (r_req.request_value[15:8] == ucdc_pkg::DT_STRING
                     && r_req.request_value[7:0] == 8'd0) begin
            n = 7'd4; w_dsrc = ucdc_pkg::SRC_S0;
        end else if (r_req.request_value[15:8] == ucdc_pkg::DT_STRING
                     && r_req.request_value[7:0] == 8'd1) begin
            n = 7'd18; w_dsrc = ucdc_pkg::SRC_S1;
        end else if (r_req.request_value[15:8] == ucdc_pkg::DT_STRING
                     && r_req.request_value[7:0] == 8'd2) begin
            n = 7'd16; w_dsrc = ucdc_pkg::SRC_S2;
        end else begin
            w_dok = 1'b0;
        end
        w_clip = ({9'd0, n} < r_req.request_length) ? n : r_req.request_length[6:0];
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_valid;
    assign w_load = ((r_state == S_EMIT) || (r_state == S_TAIL && r_qn != 2'd0))
                    && (!r_valid || o_res.ready);
    always_comb begin
        o_res.data = r_out;
        o_res.data.configured = (r_cfg_val != 8'd0);
        o_res.data.ctrl_lines = r_lines;
    end

    function automatic logic [Cw-1:0] min_chunk(input logic [6:0] rem);
        return ({{(Cw > 7 ? Cw - 7 : 0){1'b0}}, rem} < (Cw+7)'(MAX_PACKET))
               ? Cw'(rem) : Cw'(MAX_PACKET);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend_addr <= '0;
            r_cfg_val <= '0;
            r_lc <= ucdc_pkg::LC_RESET;
            r_lines <= '0;
            r_out_pend <= 1'b0;
            r_src <= '0;
            r_rem <= '0;
            r_off <= '0;
            r_qn <= '0;
            r_valid <= 1'b0;
            r_chunk_left <= '0;
        end else begin
            if (r_valid && o_res.ready && !w_load) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.data;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    // plan: start data (r_chunk_left>0) and/or queue actions
                    logic       send;
                    logic [2:0] ssrc;
                    logic [6:0] slen;
                    logic [Cw-1:0] ch;
                    send = 1'b0; ssrc = '0; slen = '0; ch = '0;
                    unique case (ucdc_pkg::t_func'(r_req.func))
                        ucdc_pkg::FUNC_SETUP: begin
                            if (r_req.request_type[6:5] == 2'd0) begin
                                priority if (r_req.request_code == ucdc_pkg::REQ_GET_STATUS) begin
                                    send = 1'b1; ssrc = ucdc_pkg::SRC_STAT; slen = 7'd2;
                                end else if (r_req.request_code == ucdc_pkg::REQ_SET_ADDRESS) begin
                                    r_pend_addr <= r_req.request_value[6:0];
                                    r_q[0] <= ucdc_pkg::ACT_ZLP; r_qn <= 2'd1;
                                end else if (r_req.request_code == ucdc_pkg::REQ_GET_DESC) begin
                                    if (w_dok) begin
                                        send = 1'b1; ssrc = w_dsrc; slen = w_clip;
                                    end else begin
                                        r_q[0] <= ucdc_pkg::ACT_ZLP; r_qn <= 2'd1;
                                    end
                                end else if (r_req.request_code == ucdc_pkg::REQ_GET_CONFIG) begin
                                    send = 1'b1; ssrc = ucdc_pkg::SRC_CFGB; slen = 7'd1;
                                end else if (r_req.request_code == ucdc_pkg::REQ_SET_CONFIG) begin
                                    r_cfg_val <= r_req.request_value[7:0];
                                    r_q[0] <= ucdc_pkg::ACT_ARM1;
                                    r_q[1] <= ucdc_pkg::ACT_ZLP; r_qn <= 2'd2;
                                end else begin
                                    r_q[0] <= ucdc_pkg::ACT_ZLP; r_qn <= 2'd1;
                                end
                            end else if (r_req.request_type[6:5] == 2'd1
                                         && r_req.request_type[4:0] == 5'd1) begin
                                priority if (r_req.request_code == ucdc_pkg::REQ_SET_LC) begin
                                    r_out_pend <= 1'b1;
                                    r_q[0] <= ucdc_pkg::ACT_ARM0; r_qn <= 2'd1;
                                end else if (r_req.request_code == ucdc_pkg::REQ_GET_LC) begin
                                    send = 1'b1; ssrc = ucdc_pkg::SRC_LC; slen = 7'd7;
                                end else if (r_req.request_code == ucdc_pkg::REQ_SET_CLS) begin
                                    r_lines <= r_req.request_value[1:0];
                                    r_q[0] <= ucdc_pkg::ACT_ZLP; r_qn <= 2'd1;
                                end else begin
                                    r_q[0] <= ucdc_pkg::ACT_ZLP; r_qn <= 2'd1;
                                end
                            end else begin
                                r_q[0] <= ucdc_pkg::ACT_ZLP; r_qn <= 2'd1;
                            end
                        end
                        ucdc_pkg::FUNC_OUT: begin
                            if (r_out_pend && r_req.out_count == 7'd7) begin
                                r_lc <= r_req.out_bytes;
                                r_out_pend <= 1'b0;
                                r_q[0] <= ucdc_pkg::ACT_ZLP;
                            end else begin
                                r_q[0] <= ucdc_pkg::ACT_NONE;
                            end
                            r_qn <= 2'd1;
                        end
                        ucdc_pkg::FUNC_IN_CPL: begin
                            if (r_rem != 7'd0) begin
                                ch = min_chunk(r_rem);
                                r_chunk_left <= ch;
                                r_rem <= r_rem - 7'(ch);
                                if (r_rem == 7'(ch)) begin
                                    // a full final packet means the total is a packet multiple
                                    if (ch == Cw'(MAX_PACKET)) begin
                                        r_q[0] <= ucdc_pkg::ACT_ZLP;
                                        r_q[1] <= ucdc_pkg::ACT_ARM0; r_qn <= 2'd2;
                                    end else begin
                                        r_q[0] <= ucdc_pkg::ACT_ARM0; r_qn <= 2'd1;
                                    end
                                end
                            end else if (r_pend_addr != 7'd0) begin
                                r_q[0] <= ucdc_pkg::ACT_ADDR; r_q_addr <= r_pend_addr;
                                r_q[1] <= ucdc_pkg::ACT_ARM0; r_qn <= 2'd2;
                                r_pend_addr <= '0;
                            end else begin
                                r_q[0] <= ucdc_pkg::ACT_ARM0; r_qn <= 2'd1;
                            end
                        end
                        default: begin
                            r_pend_addr <= '0;
                            r_cfg_val <= '0;
                            r_rem <= '0;
                            r_q[0] <= ucdc_pkg::ACT_ADDR; r_q_addr <= '0;
                            r_q[1] <= ucdc_pkg::ACT_ARM0; r_qn <= 2'd2;
                        end
                    endcase
                    if (send) begin
                        ch = min_chunk(slen);
                        r_src <= ssrc;
                        r_rem <= slen - 7'(ch);
                        r_off <= '0;
                        r_chunk_left <= ch;
                        if (slen == 7'd0) begin
                            r_q[0] <= ucdc_pkg::ACT_ZLP;
                            r_q[1] <= ucdc_pkg::ACT_ARM0; r_qn <= 2'd2;
                        end else if (slen == 7'(ch)) begin
                            r_q[0] <= ucdc_pkg::ACT_ARM0; r_qn <= 2'd1;
                        end
                    end
                    r_word <= '0;
                    r_bidx <= '0;
                    r_state <= S_WORD;
                end
                S_WORD: begin
                    // start next word or drain the queue
                    r_word <= '0;
                    r_bidx <= '0;
                    if (r_chunk_left != '0) begin
                        r_bcnt <= (r_chunk_left < Cw'(8)) ? 4'(r_chunk_left) : 4'd8;
                        r_state <= S_BYTE;
                    end else begin
                        r_state <= S_TAIL;
                    end
                end
                S_BYTE: begin
                    r_word[{r_bidx[2:0], 3'b000} +: 8] <= w_byte;
                    r_off <= r_off + 7'd1;
                    r_bidx <= r_bidx + 4'd1;
                    if (r_bidx + 4'd1 == r_bcnt) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_valid || o_res.ready) begin
                        r_valid <= 1'b1;
                        r_out.action <= ucdc_pkg::ACT_DATA;
                        r_out.data_word <= r_word;
                        r_out.byte_count <= r_bcnt;
                        r_out.packet_end <= (r_chunk_left == Cw'(r_bcnt));
                        r_out.device_address <= '0;
                        r_out.configured <= 1'b0;
                        r_out.ctrl_lines <= '0;
                        r_out.last <= (r_chunk_left == Cw'(r_bcnt)) && (r_qn == 2'd0);
                        r_chunk_left <= r_chunk_left - Cw'(r_bcnt);
                        r_state <= S_WORD;
                    end
                end
                S_TAIL: begin
                    if (r_qn == 2'd0) begin
                        if (!r_valid || o_res.ready) r_state <= S_IDLE;
                    end else if (!r_valid || o_res.ready) begin
                        r_valid <= 1'b1;
                        r_out.action <= r_q[0];
                        r_out.data_word <= '0;
                        r_out.byte_count <= '0;
                        r_out.packet_end <= 1'b0;
                        r_out.device_address <= (r_q[0] == ucdc_pkg::ACT_ADDR) ? r_q_addr : 7'd0;
                        r_out.configured <= 1'b0;
                        r_out.ctrl_lines <= '0;
                        r_out.last <= (r_qn == 2'd1);
                        r_q[0] <= r_q[1];
                        r_qn <= r_qn - 2'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("accept while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(r_out)))
        else $error("result dropped");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_out.action == ucdc_pkg::ACT_DATA) |->
        (r_out.byte_count != 4'd0 && r_out.byte_count <= 4'd8))
        else $error("bad byte count");
`endif

endmodule
`default_nettype wire
